@@ rtl/vbss_pkg.sv @@
// ----------------------------------------------------------------------------
// vbss_pkg
// Shared types, constants and codes of the volume block size selector.
// ----------------------------------------------------------------------------
`default_nettype none

package vbss_pkg;

    // Default width of one volume extent.
    localparam int DIM_WIDTH_DEF = 32;

    // Field widths fixed by the interface.
    localparam int TARGET_W  = 16;
    localparam int EDGE_W    = 9;
    localparam int CLASS_W   = 2;
    localparam int NUM_REGS  = 4;
    localparam int REG_IDX_W = 2;

    // Candidate block edges and clamps.
    localparam int EDGE_MIN           = 16;
    localparam int EDGE_MAX           = 256;
    localparam int EDGE_STEP          = 8;
    localparam int EDGE_FALLBACK      = 32;
    localparam int MIN_BLOCKS_PER_DIM = 8;
    localparam int NUM_EDGES          = (EDGE_MAX - EDGE_MIN) / EDGE_STEP + 1;

    // Every edge is a multiple of the step, so extents are first rounded up to
    // whole steps and then divided by a small constant per candidate.
    localparam int STEP_SH  = $clog2(EDGE_STEP);
    localparam int LIMIT_SH = $clog2(MIN_BLOCKS_PER_DIM);
    // An extent at or above this power of two already needs more blocks than
    // any target allows, so it is clamped there.
    localparam int CLAMP_SH = TARGET_W + $clog2(EDGE_MAX);
    // Width of a prescaled extent plus the rounding term of the division.
    localparam int XW       = CLAMP_SH - STEP_SH + 1;
    // Block counts saturate one above the largest target.
    localparam int CNT_W    = TARGET_W + 1;

    // Register reset values.
    localparam int TARGET_HDD_RST     = 400;
    localparam int TARGET_SSD_RST     = 2000;
    localparam int TARGET_NVME_RST    = 2000;
    localparam int TARGET_UNKNOWN_RST = 1000;

    typedef logic [TARGET_W-1:0] t_target;
    typedef logic [EDGE_W-1:0]   t_edge;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [XW-1:0]       t_xval;

    typedef logic [NUM_REGS-1:0][TARGET_W-1:0] t_target_set;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_HDD     = 2'd0,
        REG_TARGET_SSD     = 2'd1,
        REG_TARGET_NVME    = 2'd2,
        REG_TARGET_UNKNOWN = 2'd3
    } t_reg_index;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_NVME    = 2'd1,
        CLASS_SSD     = 2'd2,
        CLASS_HDD     = 2'd3
    } t_storage_class;

    // Data handed from the front end to the block count lanes.
    typedef struct packed {
        t_xval   xm;      // middle extent in whole steps
        t_xval   xh;      // largest extent in whole steps
        t_target target;  // block budget of the storage class
        t_edge   limit;   // per-dimension edge limit, already in range
    } t_prep;

    // Load enables of the five pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

`default_nettype wire

@@ rtl/vbss_front.sv @@
// ----------------------------------------------------------------------------
// vbss_front
// Stages one and two: sorts the extents, picks the class budget, then rounds
// the extents to whole steps and derives the per-dimension edge limit.
// ----------------------------------------------------------------------------
`default_nettype none

module vbss_front #(
    parameter int DIM_WIDTH = vbss_pkg::DIM_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire vbss_pkg::t_stage_en               i_en,
    input  wire logic [DIM_WIDTH-1:0]              i_size_x,
    input  wire logic [DIM_WIDTH-1:0]              i_size_y,
    input  wire logic [DIM_WIDTH-1:0]              i_size_z,
    input  wire logic [vbss_pkg::CLASS_W-1:0]      i_storage_class,
    input  wire vbss_pkg::t_target_set             i_targets,
    output vbss_pkg::t_prep                        o_prep
);

    logic [DIM_WIDTH-1:0] r_lo, r_mid, r_hi;
    logic [DIM_WIDTH-1:0] n_lo, n_mid, n_hi;
    vbss_pkg::t_target    r_target, n_target;
    vbss_pkg::t_prep      r_prep, n_prep;
    logic                 gab, gbc, gac;
    logic [63:0]          lo64, lim64;

    // Rounds an extent up to whole steps; large extents clamp to the point
    // where every candidate already fails.
    function automatic vbss_pkg::t_xval prescale(input logic [63:0] v);
        vbss_pkg::t_xval res;
        if ((v >> vbss_pkg::CLAMP_SH) != 64'd0) begin
            res = vbss_pkg::t_xval'(1) << (vbss_pkg::CLAMP_SH - vbss_pkg::STEP_SH);
        end else begin
            res = vbss_pkg::t_xval'(v[vbss_pkg::CLAMP_SH-1:vbss_pkg::STEP_SH])
                + vbss_pkg::t_xval'(|v[vbss_pkg::STEP_SH-1:0]);
        end
        return res;
    endfunction

    // Three-way sort from three parallel compares.
    always_comb begin
        gab = i_size_x > i_size_y;
        gbc = i_size_y > i_size_z;
        gac = i_size_x > i_size_z;

        if (gab && gac) begin
            n_hi = i_size_x;
        end else if (!gab && gbc) begin
            n_hi = i_size_y;
        end else begin
            n_hi = i_size_z;
        end

        if (!gab && !gac) begin
            n_lo = i_size_x;
        end else if (gab && !gbc) begin
            n_lo = i_size_y;
        end else begin
            n_lo = i_size_z;
        end

        if (gab ^ gac) begin
            n_mid = i_size_x;
        end else if (gab == gbc) begin
            n_mid = i_size_y;
        end else begin
            n_mid = i_size_z;
        end

        unique case (vbss_pkg::t_storage_class'(i_storage_class))
            vbss_pkg::CLASS_NVME: n_target = i_targets[vbss_pkg::REG_TARGET_NVME];
            vbss_pkg::CLASS_SSD:  n_target = i_targets[vbss_pkg::REG_TARGET_SSD];
            vbss_pkg::CLASS_HDD:  n_target = i_targets[vbss_pkg::REG_TARGET_HDD];
            default:              n_target = i_targets[vbss_pkg::REG_TARGET_UNKNOWN];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_lo     <= n_lo;
            r_mid    <= n_mid;
            r_hi     <= n_hi;
            r_target <= n_target;
        end
    end

    always_comb begin
        lo64  = 64'(r_lo);
        lim64 = lo64 >> vbss_pkg::LIMIT_SH;

        n_prep.xm     = prescale(64'(r_mid));
        n_prep.xh     = prescale(64'(r_hi));
        n_prep.target = r_target;

        if (lim64 >= 64'(vbss_pkg::EDGE_MAX)) begin
            n_prep.limit = vbss_pkg::t_edge'(vbss_pkg::EDGE_MAX);
        end else if (lim64 < 64'(vbss_pkg::EDGE_MIN)) begin
            n_prep.limit = vbss_pkg::t_edge'(vbss_pkg::EDGE_MIN);
        end else begin
            n_prep.limit = lim64[vbss_pkg::EDGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

`default_nettype wire

@@ rtl/vbss_count.sv @@
// ----------------------------------------------------------------------------
// vbss_count
// Stages three and four: one lane per candidate edge divides both extents by
// a constant through a reciprocal multiply, then tests the block product.
// ----------------------------------------------------------------------------
`default_nettype none

module vbss_count (
    input  wire logic                           i_clk,
    input  wire vbss_pkg::t_stage_en            i_en,
    input  wire vbss_pkg::t_prep                i_prep,
    output logic [vbss_pkg::NUM_EDGES-1:0]      o_pass,
    output vbss_pkg::t_edge                     o_limit
);

    localparam int PW = 2 * vbss_pkg::XW + 1;

    vbss_pkg::t_cnt    r_cm [vbss_pkg::NUM_EDGES];
    vbss_pkg::t_cnt    r_ch [vbss_pkg::NUM_EDGES];
    logic [vbss_pkg::NUM_EDGES-1:0] r_pass;
    vbss_pkg::t_target r_target3;
    vbss_pkg::t_edge   r_limit3, r_limit4;

    // Counts above the largest budget all behave the same.
    function automatic vbss_pkg::t_cnt saturate(input vbss_pkg::t_xval q);
        vbss_pkg::t_cnt res;
        if (q[vbss_pkg::XW-1:vbss_pkg::TARGET_W] != '0) begin
            res = vbss_pkg::t_cnt'(1) << vbss_pkg::TARGET_W;
        end else begin
            res = vbss_pkg::t_cnt'(q[vbss_pkg::TARGET_W-1:0]);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_target3 <= i_prep.target;
            r_limit3  <= i_prep.limit;
        end
        if (i_en.s4) begin
            r_limit4 <= r_limit3;
        end
    end

    for (genvar g = 0; g < vbss_pkg::NUM_EDGES; g++) begin : g_lane
        // Divisor in whole steps; the edge is K steps long.
        localparam longint unsigned K  = vbss_pkg::EDGE_MIN / vbss_pkg::EDGE_STEP + g;
        localparam int              SH = vbss_pkg::XW + $clog2(K);
        localparam longint unsigned M  = ((64'd1 << SH) + K - 1) / K;

        vbss_pkg::t_xval             add_m, add_h;
        logic [PW-1:0]               prod_m, prod_h;
        logic [2*vbss_pkg::CNT_W-1:0] blocks;

        // Ceiling division: floor((x + K - 1) / K), exact for every XW-bit sum.
        assign add_m  = i_prep.xm + vbss_pkg::t_xval'(K - 1);
        assign add_h  = i_prep.xh + vbss_pkg::t_xval'(K - 1);
        assign prod_m = PW'(add_m) * PW'(M);
        assign prod_h = PW'(add_h) * PW'(M);

        always_ff @(posedge i_clk) begin
            if (i_en.s3) begin
                r_cm[g] <= saturate(vbss_pkg::t_xval'(prod_m >> SH));
                r_ch[g] <= saturate(vbss_pkg::t_xval'(prod_h >> SH));
            end
        end

        assign blocks = (2*vbss_pkg::CNT_W)'(r_cm[g]) * (2*vbss_pkg::CNT_W)'(r_ch[g]);

        always_ff @(posedge i_clk) begin
            if (i_en.s4) begin
                r_pass[g] <= blocks <= (2*vbss_pkg::CNT_W)'(r_target3);
            end
        end
    end

    assign o_pass  = r_pass;
    assign o_limit = r_limit4;

endmodule

`default_nettype wire

@@ rtl/vbss_pick.sv @@
// ----------------------------------------------------------------------------
// vbss_pick
// Stage five: takes the smallest passing edge, falls back when none passes,
// and applies the per-dimension limit.
// ----------------------------------------------------------------------------
`default_nettype none

module vbss_pick (
    input  wire logic                        i_clk,
    input  wire vbss_pkg::t_stage_en         i_en,
    input  wire logic [vbss_pkg::NUM_EDGES-1:0] i_pass,
    input  wire vbss_pkg::t_edge             i_limit,
    output vbss_pkg::t_edge                  o_block_edge
);

    vbss_pkg::t_edge r_edge, n_edge, first;

    always_comb begin
        first = vbss_pkg::t_edge'(vbss_pkg::EDGE_FALLBACK);
        // Scan from the top so the smallest passing edge wins.
        for (int i = vbss_pkg::NUM_EDGES - 1; i >= 0; i--) begin
            if (i_pass[i]) begin
                first = vbss_pkg::t_edge'(vbss_pkg::EDGE_MIN + vbss_pkg::EDGE_STEP * i);
            end
        end
        // The limit is already within the legal edge range, so the final
        // clamp reduces to this minimum.
        n_edge = (first > i_limit) ? i_limit : first;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_edge <= n_edge;
        end
    end

    assign o_block_edge = r_edge;

endmodule

`default_nettype wire

@@ rtl/volume_block_size_select.sv @@
// ----------------------------------------------------------------------------
// volume_block_size_select
// Chooses a cubic tiling block edge for a volume from its three extents and
// a storage class, against a programmable block budget per class.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   --------  ---------  ---------------------  --------------------------------
//   query     in         i_valid / o_stall      i_size_x, i_size_y, i_size_z,
//                                               i_storage_class
//   result    out        o_valid / i_stall      o_block_edge
//   config    in         i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// One query transfer can be taken on every clock cycle while o_stall is low,
// and each query gives exactly one result, in order.
// The five stages are: sort and budget select, step rounding and limit,
// reciprocal divides in 31 parallel candidate lanes, block product test,
// and first-pass selection into the output register.
// Every stage has its own valid bit. A stall on the result side freezes only
// the stages that hold data, so bubbles further up still fill and o_stall
// rises only when all five stages are occupied.
// Reset is synchronous and active low; it empties the pipeline and restores
// the four budget registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_block_size_select #(
    parameter int DIM_WIDTH = vbss_pkg::DIM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [DIM_WIDTH-1:0]               i_size_x,
    input  wire logic [DIM_WIDTH-1:0]               i_size_y,
    input  wire logic [DIM_WIDTH-1:0]               i_size_z,
    input  wire logic [vbss_pkg::CLASS_W-1:0]       i_storage_class,

    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [vbss_pkg::EDGE_W-1:0]             o_block_edge,

    input  wire logic                               i_cfg_wr_en,
    input  wire logic [vbss_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vbss_pkg::TARGET_W-1:0]      i_cfg_data
);

    // Budget registers, one per storage class, addressed by register index.
    vbss_pkg::t_target_set r_targets;

    // Stage valid bits, index 0 is the first stage.
    logic [4:0] r_vld, n_vld;
    logic [4:0] rdy;
    vbss_pkg::t_stage_en en;

    vbss_pkg::t_prep                prep;
    logic [vbss_pkg::NUM_EDGES-1:0] pass;
    vbss_pkg::t_edge                limit;
    vbss_pkg::t_edge                block_edge;

    // Configuration writes land directly; user must idle the block; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_targets[vbss_pkg::REG_TARGET_HDD]     <= vbss_pkg::t_target'(vbss_pkg::TARGET_HDD_RST);
            r_targets[vbss_pkg::REG_TARGET_SSD]     <= vbss_pkg::t_target'(vbss_pkg::TARGET_SSD_RST);
            r_targets[vbss_pkg::REG_TARGET_NVME]    <= vbss_pkg::t_target'(vbss_pkg::TARGET_NVME_RST);
            r_targets[vbss_pkg::REG_TARGET_UNKNOWN] <=
                vbss_pkg::t_target'(vbss_pkg::TARGET_UNKNOWN_RST);
        end else if (i_cfg_wr_en) begin
            unique case (vbss_pkg::t_reg_index'(i_cfg_index))
                vbss_pkg::REG_TARGET_HDD:  r_targets[vbss_pkg::REG_TARGET_HDD]  <= i_cfg_data;
                vbss_pkg::REG_TARGET_SSD:  r_targets[vbss_pkg::REG_TARGET_SSD]  <= i_cfg_data;
                vbss_pkg::REG_TARGET_NVME: r_targets[vbss_pkg::REG_TARGET_NVME] <= i_cfg_data;
                default: r_targets[vbss_pkg::REG_TARGET_UNKNOWN] <= i_cfg_data;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        rdy[4] = !r_vld[4] || !i_stall;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end

        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < 5; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end

        en.s1 = rdy[0];
        en.s2 = rdy[1];
        en.s3 = rdy[2];
        en.s4 = rdy[3];
        en.s5 = rdy[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    vbss_front #(
        .DIM_WIDTH(DIM_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_size_x       (i_size_x),
        .i_size_y       (i_size_y),
        .i_size_z       (i_size_z),
        .i_storage_class(i_storage_class),
        .i_targets      (r_targets),
        .o_prep         (prep)
    );

    vbss_count u_count (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_prep (prep),
        .o_pass (pass),
        .o_limit(limit)
    );

    vbss_pick u_pick (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_pass      (pass),
        .i_limit     (limit),
        .o_block_edge(block_edge)
    );

    assign o_stall      = !rdy[0];
    assign o_valid      = r_vld[4];
    assign o_block_edge = block_edge;

`ifndef ASSERT_OFF
    // A query transfer always occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted query did not enter the first stage");

    // Back pressure reaches the query side only when every stage is full.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("query side stalled while a stage was free");

    // Every delivered edge lies in the legal range.
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_block_edge >= vbss_pkg::t_edge'(vbss_pkg::EDGE_MIN)
                     && o_block_edge <= vbss_pkg::t_edge'(vbss_pkg::EDGE_MAX)))
        else $error("block edge out of range");
`endif

endmodule

`default_nettype wire

@@ tb/volume_block_size_select_test.sv @@
// ----------------------------------------------------------------------------
// volume_block_size_select_test
// Self-checking testbench for the volume block size selector. A behavioral
// predictor computes the block edge of every accepted query from its own copy
// of the four budget registers, and each result transfer is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_block_size_select_test;

    import vbss_pkg::*;

    // Generous cap on the run, far beyond the slowest legal schedule.
    localparam longint CYCLE_LIMIT  = 400000;
    // Pipeline depth of the block; used for settling time after a drain.
    localparam int     PIPE_LATENCY = 5;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_valid         = 1'b0;
    logic                   o_stall;
    logic [DIM_WIDTH_DEF-1:0] i_size_x      = '0;
    logic [DIM_WIDTH_DEF-1:0] i_size_y      = '0;
    logic [DIM_WIDTH_DEF-1:0] i_size_z      = '0;
    logic [CLASS_W-1:0]     i_storage_class = '0;
    logic                   o_valid;
    logic                   i_stall         = 1'b0;
    logic [EDGE_W-1:0]      o_block_edge;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [TARGET_W-1:0]    i_cfg_data      = '0;

    // Expected block edges, oldest first, one per accepted query.
    t_edge       edge_expected[$];
    // Our copy of the budget registers, indexed by register index.
    t_target     budget_reg[NUM_REGS] = '{TARGET_HDD_RST, TARGET_SSD_RST,
                                          TARGET_NVME_RST, TARGET_UNKNOWN_RST};
    int unsigned error_count  = 0;
    // When set, neither side inserts idle cycles between transfers.
    bit          no_idle      = 1'b0;
    // A request for a long receiver hold-off, picked up by the receiver.
    int          hold_request = 0;
    longint      cycle_count  = 0;

    volume_block_size_select i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_size_x        (i_size_x),
        .i_size_y        (i_size_y),
        .i_size_z        (i_size_z),
        .i_storage_class (i_storage_class),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_block_edge    (o_block_edge),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Behavioral block edge selection. All arithmetic is done in 64 bits so
    // that neither the ceiling division nor the budget test can wrap.
    function automatic t_edge predict_edge(input logic [31:0] sx, sy, sz,
                                           input t_storage_class cls);
        longint unsigned lo, mid, hi, tmp, budget, limit, edge_len, bs, cm, ch;
        bit              found;
        lo  = sx;
        mid = sy;
        hi  = sz;
        if (lo > mid) begin tmp = lo; lo = mid; mid = tmp; end
        if (mid > hi) begin tmp = mid; mid = hi; hi = tmp; end
        if (lo > mid) begin tmp = lo; lo = mid; mid = tmp; end
        case (cls)
            CLASS_NVME: begin
                budget = budget_reg[REG_TARGET_NVME];
            end
            CLASS_SSD: begin
                budget = budget_reg[REG_TARGET_SSD];
            end
            CLASS_HDD: begin
                budget = budget_reg[REG_TARGET_HDD];
            end
            default: begin
                budget = budget_reg[REG_TARGET_UNKNOWN];
            end
        endcase
        // Scan candidate edges; a zero block count along either axis always
        // passes, and a zero budget passes nothing else.
        edge_len = EDGE_FALLBACK;
        found    = 1'b0;
        for (bs = EDGE_MIN; bs <= EDGE_MAX && !found; bs += EDGE_STEP) begin
            cm = (mid + bs - 1) / bs;
            ch = (hi + bs - 1) / bs;
            if (cm == 0 || ch == 0 || ch <= budget / cm) begin
                edge_len = bs;
                found    = 1'b1;
            end
        end
        // The smallest extent must still hold several blocks.
        limit = lo / MIN_BLOCKS_PER_DIM;
        if (limit < EDGE_MIN) limit = EDGE_MIN;
        if (edge_len > limit) edge_len = limit;
        if (edge_len < EDGE_MIN) edge_len = EDGE_MIN;
        if (edge_len > EDGE_MAX) edge_len = EDGE_MAX;
        return t_edge'(edge_len);
    endfunction

    // Extents spread over all magnitudes, with extra weight near multiples
    // of candidate edges where the ceiling division changes value.
    function automatic logic [31:0] random_extent();
        int unsigned bits;
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: begin
                v = $urandom_range(0, 64);
            end
            1: begin
                v = $urandom();
            end
            2: begin
                v = 32'(8 * $urandom_range(2, 32)) * 32'($urandom_range(1, 256))
                    + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: begin
                bits = $urandom_range(1, 32);
                v    = $urandom() >> (32 - bits);
            end
        endcase
        return v;
    endfunction

    function automatic t_target random_budget();
        t_target v;
        case ($urandom_range(0, 3))
            0: begin
                v = t_target'($urandom_range(1, 16));
            end
            1: begin
                v = t_target'($urandom());
            end
            2: begin
                v = t_target'($urandom() >> (32 - $urandom_range(1, 16)));
                if (v == 0) v = 1;
            end
            default: begin
                v = ($urandom_range(0, 1) != 0) ? t_target'(1) : '1;
            end
        endcase
        return v;
    endfunction

    // Offers one query after a random gap (none if no_idle) and holds it until
    // the block takes it. The expected edge is recorded at the transfer edge.
    task automatic send_query(input logic [31:0] sx, sy, sz,
                              input t_storage_class cls);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_size_x        <= sx;
        i_size_y        <= sy;
        i_size_z        <= sz;
        i_storage_class <= cls;
        do @(posedge i_clk); while (o_stall);
        edge_expected.insert(edge_expected.size(), predict_edge(sx, sy, sz, cls));
    endtask

    task automatic send_random_query();
        send_query(random_extent(), random_extent(), random_extent(),
                   t_storage_class'($urandom_range(0, 3)));
    endtask

    // Stops offering and waits until every expected result has arrived,
    // then lets the pipeline settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (edge_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    // Writes all four budget registers, one per cycle, while the block idles.
    task automatic load_budgets(input t_target hdd_v, ssd_v, nvme_v, unk_v);
        t_reg_index reg_list[NUM_REGS];
        t_target    val_list[NUM_REGS];
        reg_list = '{REG_TARGET_HDD, REG_TARGET_SSD, REG_TARGET_NVME, REG_TARGET_UNKNOWN};
        val_list = '{hdd_v, ssd_v, nvme_v, unk_v};
        i_cfg_wr_en <= 1'b1;
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_index <= reg_list[r];
            i_cfg_data  <= val_list[r];
            @(posedge i_clk);
            budget_reg[reg_list[r]] = val_list[r];
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Extremes of the extents and every storage class at the reset budgets:
    // zero extents, full-scale extents, tiny volumes, each axis as the
    // largest, and a volume where no edge passes so the fallback is used.
    task automatic test_directed_extremes();
        send_query(32'd0, 32'd0, 32'd0, CLASS_UNKNOWN);
        send_query('1, '1, '1, CLASS_UNKNOWN);
        send_query('1, '1, '1, CLASS_NVME);
        send_query('1, '1, '1, CLASS_SSD);
        send_query('1, '1, '1, CLASS_HDD);
        send_query(32'd1, 32'd1, 32'd1, CLASS_HDD);
        send_query(32'd16, 32'd16, 32'd16, CLASS_SSD);
        // A zero extent is the smallest, so the limit pins the edge to EDGE_MIN.
        send_query(32'd0, '1, '1, CLASS_HDD);
        send_query('1, 32'd0, '1, CLASS_NVME);
        send_query('1, '1, 32'd0, CLASS_SSD);
        // Fallback edge: nothing fits, yet the smallest extent allows it.
        send_query('1, '1, 32'h0001_0000, CLASS_HDD);
        send_query(32'h0001_0000, '1, '1, CLASS_UNKNOWN);
        // Per-dimension limit just at and around the largest edge.
        send_query(32'd2048, 32'd2048, 32'd2048, CLASS_UNKNOWN);
        send_query(32'd2047, 32'd4096, 32'd4096, CLASS_UNKNOWN);
        send_query(32'd4096, 32'd2048, 32'd4096, CLASS_HDD);
        send_query(32'd4096, 32'd4096, 32'd2048, CLASS_NVME);
        // Largest extent on each axis in turn.
        send_query(32'd1 << 20, 32'd65536, 32'd4096, CLASS_SSD);
        send_query(32'd4096, 32'd1 << 20, 32'd65536, CLASS_SSD);
        send_query(32'd65536, 32'd4096, 32'd1 << 20, CLASS_SSD);
        send_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, CLASS_UNKNOWN);
        drain();
    endtask

    // Budget register extremes, including a zero budget where only a zero
    // block product passes.
    task automatic test_budget_settings();
        load_budgets(16'd1, 16'd1, 16'd1, 16'd1);
        repeat (25) send_random_query();
        drain();
        load_budgets('1, '1, '1, '1);
        repeat (25) send_random_query();
        drain();
        load_budgets(16'd0, 16'd0, 16'd0, 16'd0);
        send_query(32'd0, '1, '1, CLASS_HDD);
        repeat (24) send_random_query();
        drain();
        load_budgets(16'd0, 16'd1, '1, 16'd400);
        repeat (25) send_random_query();
        drain();
    endtask

    // The receiver holds off long enough for all stages to fill and the
    // input to stall, while the sender keeps offering back to back.
    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = 80;
        repeat (40) send_random_query();
        no_idle = 1'b0;
        drain();
    endtask

    // Random queries over several budget settings, some phases with both
    // sides running at full rate.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            if (phase > 0) begin
                load_budgets(random_budget(), random_budget(), random_budget(),
                             random_budget());
            end
            no_idle = (phase % 3 == 2);
            repeat (200) send_random_query();
            drain();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: after each result transfer it draws a random stall, none when
    // no_idle is set. A hold-off request overrides this with one long stall.
    always @(posedge i_clk) begin : result_receiver
        static int stall_left = 0;
        static int hold_left  = 0;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && !i_stall) begin
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
            end
        end
    end

    // Every result transfer is matched against the oldest expected edge.
    always @(posedge i_clk) begin : edge_checker
        t_edge want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (edge_expected.size() == 0) begin
                $error("block_edge: unexpected result %0d, nothing pending", o_block_edge);
                error_count++;
            end else begin
                want = edge_expected.pop_front();
                if (o_block_edge !== want) begin
                    $error("block_edge: expected %0d, actual %0d", want, o_block_edge);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_budget_settings();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (error_count == 0 && edge_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
